@@ hdl/mbp_pkg.sv @@
`timescale 1ns / 1ps
// mbp_pkg: shared types and constants of the msb-first bit packer
// used by mbp_ctrl, mbp_datapath and msb_first_bit_packer_core
package mbp_pkg;

  localparam int CODE_BITS     = 32;
  localparam int MAX_CODE_BITS = 32;
  localparam int CODE_LIMIT    = (MAX_CODE_BITS < CODE_BITS) ? MAX_CODE_BITS : CODE_BITS;
  localparam int BYTE_BITS     = 8;
  localparam int BUF_BITS      = CODE_BITS + BYTE_BITS;
  localparam int COUNT_BITS    = 6;
  localparam int FILL_BITS     = 3;
  localparam int LEFT_BITS     = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } dp_cmd_t;

  typedef struct packed {
    logic load_has_bytes;
    logic last_byte;
    logic none_left;
  } dp_sts_t;

endpackage

@@ hdl/mbp_ctrl.sv @@
`timescale 1ns / 1ps
// mbp_ctrl: state machine that takes an item and drains its bytes
// depends on mbp_pkg
module mbp_ctrl
  import mbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && sts.load_has_bytes) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall && sts.last_byte) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.shift = !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ hdl/mbp_datapath.sv @@
`timescale 1ns / 1ps
// mbp_datapath: bit buffer, fill count and byte counter of the packer
// depends on mbp_pkg
module mbp_datapath
  import mbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  input  logic                  command,
  input  logic [CODE_BITS-1:0]  code,
  input  logic [COUNT_BITS-1:0] count,
  output logic [BYTE_BITS-1:0]  out_byte,
  output logic                  last,
  output dp_sts_t               sts
);

  logic [BUF_BITS-1:0]   bits;
  logic [FILL_BITS-1:0]  filled;
  logic [LEFT_BITS-1:0]  bytes_left;

  logic [COUNT_BITS-1:0] cnt_sat;
  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] shamt;
  logic [CODE_BITS-1:0]  masked;
  logic [BUF_BITS-1:0]   placed;
  logic [BUF_BITS-1:0]   top_only;

  always_comb begin
    cnt_sat  = (count > COUNT_BITS'(CODE_LIMIT)) ? COUNT_BITS'(CODE_LIMIT) : count;
    total    = COUNT_BITS'(filled) + cnt_sat;
    shamt    = COUNT_BITS'(BUF_BITS) - COUNT_BITS'(filled) - cnt_sat;
    masked   = code & ~({CODE_BITS{1'b1}} << cnt_sat);
    placed   = {{BYTE_BITS{1'b0}}, masked} << shamt;
    top_only = {bits[BUF_BITS-1 -: BYTE_BITS], {CODE_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits       <= '0;
      filled     <= '0;
      bytes_left <= '0;
    end else if (cmd.load) begin
      if (command == CMD_FLUSH) begin
        bits       <= top_only;
        filled     <= '0;
        bytes_left <= LEFT_BITS'(filled != '0);
      end else begin
        bits       <= top_only | placed;
        filled     <= total[FILL_BITS-1:0];
        bytes_left <= total[COUNT_BITS-1:FILL_BITS];
      end
    end else if (cmd.shift) begin
      bits       <= {bits[BUF_BITS-BYTE_BITS-1:0], {BYTE_BITS{1'b0}}};
      bytes_left <= bytes_left - LEFT_BITS'(1);
    end
  end

  assign out_byte = bits[BUF_BITS-1 -: BYTE_BITS];
  assign last     = (bytes_left == LEFT_BITS'(1));

  always_comb begin
    sts.load_has_bytes = (command == CMD_FLUSH) ? (filled != '0)
                                                : (total[COUNT_BITS-1:FILL_BITS] != '0);
    sts.last_byte      = (bytes_left == LEFT_BITS'(1));
    sts.none_left      = (bytes_left == '0);
  end

endmodule

@@ hdl/msb_first_bit_packer_core.sv @@
`timescale 1ns / 1ps
// Packs codes of 1 to 32 bits, most significant bit first, into bytes. An item with
// command write appends the low count bits of code (counts above 32 act as 32); an item
// with command flush emits the partial byte, zero padded, if it holds any bits, then
// clears it. Bytes leave on the output channel with last set on the final byte of each
// item. An item is taken while the block is idle, and its n completed bytes (0 to 4) then
// drain one per cycle, unless out_stall holds them, from the 40-bit shift buffer that also
// serves as output register; no new item is taken while bytes of the current one are still
// draining.
// depends on mbp_pkg, mbp_ctrl and mbp_datapath
module msb_first_bit_packer_core
  import mbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [CODE_BITS-1:0]  code,
  input  logic [COUNT_BITS-1:0] count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_BITS-1:0]  out_byte,
  output logic                  last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .command  (command),
    .code     (code),
    .count    (count),
    .out_byte (out_byte),
    .last     (last),
    .sts      (sts)
  );

`ifndef SYNTHESIS
  a_valid_has_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !sts.none_left)
    else $error("output valid with no bytes left");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid)
    else $error("output still valid after last byte");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("burst ended before last byte");

  a_no_take_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item taken while bytes pending");
`endif

endmodule
